// ===== rtl/core/pclp_pkg.sv =====
// Package for the pump command line parser.
// Holds the byte class record, the pattern phase codes and the pattern text lookup.
// No dependencies.
package pclp_pkg;

	localparam int LINE_SIZE_DEF = 64;

	// Depth of the queue between the classifier and the parser.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [6:0] DUTY_MAX = 7'd100;

	// Position in the pattern "PUMP=<digits>,TIME=<digits>".
	localparam logic [3:0] PH_HEAD0      = 4'd0;
	localparam logic [3:0] PH_HEAD1      = 4'd1;
	localparam logic [3:0] PH_HEAD2      = 4'd2;
	localparam logic [3:0] PH_HEAD3      = 4'd3;
	localparam logic [3:0] PH_HEAD4      = 4'd4;
	localparam logic [3:0] PH_DUTY_FIRST = 4'd5;
	localparam logic [3:0] PH_DUTY_MORE  = 4'd6;
	localparam logic [3:0] PH_TIME_TEXT  = 4'd7;
	localparam logic [3:0] PH_TIME1      = 4'd8;
	localparam logic [3:0] PH_TIME2      = 4'd9;
	localparam logic [3:0] PH_TIME3      = 4'd10;
	localparam logic [3:0] PH_TIME4      = 4'd11;
	localparam logic [3:0] PH_TIME_FIRST = 4'd12;
	localparam logic [3:0] PH_TIME_MORE  = 4'd13;
	localparam logic [3:0] PH_DONE       = 4'd14;
	localparam logic [3:0] PH_ERROR      = 4'd15;

	// One request after classification.
	typedef struct packed {
		logic       rx_err;
		logic       is_nl;
		logic       is_cr;
		logic       is_nul;
		logic       is_digit;
		logic       is_comma;
		logic [3:0] digit;
		logic [7:0] ch;
	} byte_class_t;

	// Character expected at each literal position of the pattern.
	function automatic logic [7:0] expected_char(input logic [3:0] phase);
		logic [7:0] c;
		unique case (phase)
			PH_HEAD0: c = 8'h50;
			PH_HEAD1: c = 8'h55;
			PH_HEAD2: c = 8'h4d;
			PH_HEAD3: c = 8'h50;
			PH_HEAD4: c = 8'h3d;
			PH_TIME_TEXT: c = 8'h54;
			PH_TIME1: c = 8'h49;
			PH_TIME2: c = 8'h4d;
			PH_TIME3: c = 8'h45;
			PH_TIME4: c = 8'h3d;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/pump_command_line_parser_core.sv =====
// Top level of the pump command line parser.
// Depends on pclp_pkg, pclp_front, pclp_queue and pclp_back.
//
//  channel  direction  handshake             payload
//  input    in         in_valid / in_stall   op, rx_byte
//  result   out        out_valid / out_stall cmd_valid, duty_pct, run_ms
//  config   in         cfg_wr_en             cfg_wr_data (run time limit)
//
// One request is taken per cycle while the queue is not full. The parser handles
// one queued request per cycle; a newline waits in the two-entry queue only while
// the result register holds a result that is stalled, so the input stalls only once
// the queue is full. A result appears in the cycle after its newline leaves the queue.
// Reset clears the line state and the queue and sets the run time limit to 60000.
module pump_command_line_parser_core #(
	parameter int LINE_SIZE = pclp_pkg::LINE_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        cmd_valid,
	output logic [6:0]  duty_pct,
	output logic [31:0] run_ms
);
	import pclp_pkg::*;

	byte_class_t cls;
	byte_class_t q_data;
	logic        q_full;
	logic        q_not_empty;
	logic        q_pop;
	logic        push;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	pclp_front u_front (
		.op      (op),
		.rx_byte (rx_byte),
		.cls     (cls)
	);

	pclp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cls),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_data)
	);

	pclp_back #(
		.LINE_SIZE (LINE_SIZE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_not_empty (q_not_empty),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cmd_valid   (cmd_valid),
		.duty_pct    (duty_pct),
		.run_ms      (run_ms)
	);

endmodule

// ===== rtl/core/pclp_front.sv =====
// Front end of the pump command line parser: classifies each incoming request.
// Depends on pclp_pkg.
module pclp_front (
	input  logic                  op,
	input  logic [7:0]            rx_byte,
	output pclp_pkg::byte_class_t cls
);
	import pclp_pkg::*;

	logic [7:0] digit_off;

	assign digit_off = rx_byte - CH_ZERO;

	always_comb begin
		cls.rx_err   = op;
		cls.is_nl    = (rx_byte == CH_NL);
		cls.is_cr    = (rx_byte == CH_CR);
		cls.is_nul   = (rx_byte == 8'h00);
		cls.is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
		cls.is_comma = (rx_byte == CH_COMMA);
		cls.digit    = digit_off[3:0];
		cls.ch       = rx_byte;
	end

endmodule

// ===== rtl/core/pclp_queue.sv =====
// Short queue of classified requests between the front end and the parser.
// Depends on pclp_pkg.
module pclp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pclp_pkg::byte_class_t push_data,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output pclp_pkg::byte_class_t pop_data
);
	import pclp_pkg::*;

	byte_class_t         entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] n;
		if (p == QPTR_W'(QDEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + QPTR_W'(1);
		end
		return n;
	endfunction

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/pclp_back.sv =====
// Back end of the pump command line parser: line assembly, pattern parsing,
// number accumulation, the run time limit register and the result register.
// Depends on pclp_pkg.
module pclp_back #(
	parameter int LINE_SIZE = pclp_pkg::LINE_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [31:0]           cfg_wr_data,
	input  logic                  q_not_empty,
	input  pclp_pkg::byte_class_t q_data,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  cmd_valid,
	output logic [6:0]            duty_pct,
	output logic [31:0]           run_ms
);
	import pclp_pkg::*;

	localparam int CNT_W = $clog2(LINE_SIZE);

	logic [31:0]      max_dur_q;
	logic [CNT_W-1:0] count_q;
	logic             discard_q;
	logic [3:0]       phase_q;
	logic [31:0]      accum_q;
	logic             ovf_q;
	logic [6:0]       duty_q;
	logic             duty_big_q;

	logic [CNT_W-1:0] count_d;
	logic             discard_d;
	logic [3:0]       phase_d;
	logic [31:0]      accum_d;
	logic             ovf_d;
	logic [6:0]       duty_d;
	logic             duty_big_d;

	logic             out_valid_q;
	logic             cmd_valid_q;
	logic [6:0]       duty_out_q;
	logic [31:0]      dur_out_q;

	logic [35:0]      accum_x10;
	logic             add_ovf;
	logic             give;
	logic             line_ok;
	logic             emit;

	// accum * 10 + digit, with the carry bits telling a 32-bit overflow.
	assign accum_x10 = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0}
		+ {32'd0, q_data.digit};
	assign add_ovf = |accum_x10[35:32];

	// A newline request waits only while the result register is full and stalled.
	assign q_pop = q_not_empty && (!q_data.is_nl || !q_data.rx_err && !out_valid_q
		|| q_data.rx_err || !out_stall);

	assign give    = !discard_q && (count_q != '0);
	assign line_ok = ((phase_q == PH_TIME_MORE) || (phase_q == PH_DONE)) && !ovf_q
		&& !duty_big_q && (accum_q <= max_dur_q) && !((duty_q != '0) && (accum_q == '0));
	assign emit    = q_pop && !q_data.rx_err && q_data.is_nl && give;

	always_comb begin
		count_d    = count_q;
		discard_d  = discard_q;
		phase_d    = phase_q;
		accum_d    = accum_q;
		ovf_d      = ovf_q;
		duty_d     = duty_q;
		duty_big_d = duty_big_q;
		priority if (q_data.rx_err || q_data.is_nl) begin
			count_d    = '0;
			discard_d  = 1'b0;
			phase_d    = PH_HEAD0;
			accum_d    = '0;
			ovf_d      = 1'b0;
			duty_d     = '0;
			duty_big_d = 1'b0;
		end else if (q_data.is_cr || discard_q) begin
			// Nothing is stored or parsed.
		end else if (count_q == CNT_W'(LINE_SIZE - 1)) begin
			count_d    = '0;
			discard_d  = 1'b1;
			phase_d    = PH_HEAD0;
			accum_d    = '0;
			ovf_d      = 1'b0;
			duty_d     = '0;
			duty_big_d = 1'b0;
		end else begin
			count_d = count_q + CNT_W'(1);
			priority if ((phase_q == PH_DONE) || (phase_q == PH_ERROR)) begin
				// The text has ended or already failed.
			end else if (q_data.is_nul) begin
				phase_d = (phase_q == PH_TIME_MORE) ? PH_DONE : PH_ERROR;
			end else if ((phase_q == PH_DUTY_FIRST) || (phase_q == PH_TIME_FIRST)
					|| (phase_q == PH_TIME_MORE)
					|| ((phase_q == PH_DUTY_MORE) && q_data.is_digit)) begin
				if (!q_data.is_digit) begin
					phase_d = PH_ERROR;
				end else if (add_ovf) begin
					ovf_d   = 1'b1;
					phase_d = PH_ERROR;
				end else begin
					accum_d = accum_x10[31:0];
					if ((phase_q == PH_DUTY_FIRST) || (phase_q == PH_TIME_FIRST)) begin
						phase_d = phase_q + 4'd1;
					end
				end
			end else if (phase_q == PH_DUTY_MORE) begin
				if (q_data.is_comma) begin
					duty_big_d = (accum_q > {25'd0, DUTY_MAX});
					duty_d     = (accum_q > {25'd0, DUTY_MAX}) ? 7'd0 : accum_q[6:0];
					accum_d    = '0;
					phase_d    = PH_TIME_TEXT;
				end else begin
					phase_d = PH_ERROR;
				end
			end else begin
				// Literal text of the pattern.
				phase_d = (q_data.ch == expected_char(phase_q)) ? phase_q + 4'd1 : PH_ERROR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dur_q  <= 32'd60000;
			count_q    <= '0;
			discard_q  <= 1'b0;
			phase_q    <= PH_HEAD0;
			accum_q    <= '0;
			ovf_q      <= 1'b0;
			duty_q     <= '0;
			duty_big_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_dur_q <= cfg_wr_data;
			end
			if (q_pop) begin
				count_q    <= count_d;
				discard_q  <= discard_d;
				phase_q    <= phase_d;
				accum_q    <= accum_d;
				ovf_q      <= ovf_d;
				duty_q     <= duty_d;
				duty_big_q <= duty_big_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cmd_valid_q <= line_ok;
			duty_out_q  <= line_ok ? duty_q : 7'd0;
			dur_out_q   <= (line_ok && (duty_q != '0)) ? accum_q : 32'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign cmd_valid = cmd_valid_q;
	assign duty_pct  = duty_out_q;
	assign run_ms    = dur_out_q;

endmodule

// ===== rtl/core/pclp_checker.sv =====
// Port level checks for the pump command line parser, bound to the top level.
// Depends only on the top level's ports.
module pclp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        cmd_valid,
	input logic [6:0]  duty_pct,
	input logic [31:0] run_ms
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(cmd_valid) && $stable(duty_pct)
			&& $stable(run_ms))
		else $error("stalled result changed");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cmd_valid |-> (duty_pct == 7'd0) && (run_ms == 32'd0))
		else $error("invalid line result carries nonzero values");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> duty_pct <= 7'd100)
		else $error("duty above 100 percent");

	a_zero_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (duty_pct == 7'd0) |-> run_ms == 32'd0)
		else $error("run time given with zero duty");

endmodule

bind pump_command_line_parser_core pclp_checker u_pclp_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the pump command line parser core.
// Drives received bytes and receive errors with random gaps and stalls, and checks each
// command result against an in-bench parser. Depends on pclp_pkg and the core only.
module tb;
	import pclp_pkg::*;

	localparam int LINE_LEN = LINE_SIZE_DEF;
	localparam logic [39:0] HEAD_STR = "PUMP=";
	localparam logic [39:0] TIME_STR = "TIME=";
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_RX_ERR = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] ch;
	} rx_req_t;

	typedef struct packed {
		logic        ok;
		logic [6:0]  duty;
		logic [31:0] dur;
	} pump_cmd_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic        cmd_valid;
	logic [6:0]  duty_pct;
	logic [31:0] run_ms;

	rx_req_t   pending_reqs[$];
	pump_cmd_t expected_cmds[$];
	int        send_idle_pct = 0;
	int        stall_pct = 0;
	int        mismatches = 0;
	int        items_sent = 0;
	logic      in_taken = 1'b0;

	// Parser state mirrored in the bench.
	logic [31:0] limit_ms = 32'd60000;
	int          ln_count = 0;
	logic        dropping = 1'b0;
	logic [3:0]  ph = PH_HEAD0;
	logic [31:0] acc = '0;
	logic        acc_ovf = 1'b0;
	logic [6:0]  duty_cap = '0;
	logic        duty_big = 1'b0;

	pump_command_line_parser_core #(
		.LINE_SIZE(LINE_LEN)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd_valid(cmd_valid),
		.duty_pct(duty_pct),
		.run_ms(run_ms)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic clear_line_state();
		ln_count = 0;
		dropping = 1'b0;
		ph = PH_HEAD0;
		acc = '0;
		acc_ovf = 1'b0;
		duty_cap = '0;
		duty_big = 1'b0;
	endtask

	task automatic add_digit(input logic [3:0] d);
		logic [35:0] w;
		w = {4'd0, acc} * 36'd10 + {32'd0, d};
		if (w[35:32] != 4'd0) begin
			acc_ovf = 1'b1;
			ph = PH_ERROR;
		end else begin
			acc = w[31:0];
		end
	endtask

	// Advances the pattern match by one stored character.
	task automatic match_char(input logic [7:0] c);
		logic       is_dig;
		logic [3:0] d;
		is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
		d = c[3:0];
		if (ph == PH_DONE || ph == PH_ERROR)
			return;
		if (c == 8'h00) begin
			ph = (ph == PH_TIME_MORE) ? PH_DONE : PH_ERROR;
			return;
		end
		if (ph < PH_DUTY_FIRST) begin
			ph = (c == HEAD_STR[39 - 8 * ph -: 8]) ? ph + 4'd1 : PH_ERROR;
		end else if (ph == PH_DUTY_FIRST || ph == PH_TIME_FIRST) begin
			if (is_dig) begin
				ph = ph + 4'd1;
				add_digit(d);
			end else begin
				ph = PH_ERROR;
			end
		end else if (ph == PH_DUTY_MORE) begin
			if (is_dig) begin
				add_digit(d);
			end else if (c == CH_COMMA) begin
				duty_big = acc > 32'd100;
				duty_cap = duty_big ? 7'd0 : acc[6:0];
				acc = '0;
				ph = PH_TIME_TEXT;
			end else begin
				ph = PH_ERROR;
			end
		end else if (ph < PH_TIME_FIRST) begin
			ph = (c == TIME_STR[39 - 8 * (ph - PH_TIME_TEXT) -: 8]) ? ph + 4'd1 : PH_ERROR;
		end else begin
			if (is_dig)
				add_digit(d);
			else
				ph = PH_ERROR;
		end
	endtask

	// Applies one accepted request and queues the command it yields, if any.
	task automatic parse_request(input logic is_err, input logic [7:0] c);
		pump_cmd_t cmd;
		logic      good;
		if (is_err == OP_RX_ERR) begin
			clear_line_state();
		end else if (c == CH_NL) begin
			good = (ph == PH_TIME_MORE || ph == PH_DONE) && !acc_ovf && !duty_big &&
				(acc <= limit_ms) && !((duty_cap != 7'd0) && (acc == 32'd0));
			if (!dropping && ln_count != 0) begin
				cmd.ok = good;
				cmd.duty = good ? duty_cap : 7'd0;
				cmd.dur = (good && duty_cap != 7'd0) ? acc : 32'd0;
				expected_cmds.push_back(cmd);
			end
			clear_line_state();
		end else if (c != CH_CR && !dropping) begin
			if (ln_count < LINE_LEN - 1) begin
				ln_count++;
				match_char(c);
			end else begin
				clear_line_state();
				dropping = 1'b1;
			end
		end
	endtask

	task automatic report_mismatch(input string what, input pump_cmd_t want,
			input pump_cmd_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected ok=%0d duty=%0d dur=%0d, got ok=%0d duty=%0d dur=%0d",
				$time, what, want.ok, want.duty, want.dur, got.ok, got.duty, got.dur);
	endtask

	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
	end

	always @(negedge clk) begin : drive
		rx_req_t req;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req = pending_reqs.pop_front();
					in_valid <= 1'b1;
					op <= req.op;
					rx_byte <= req.ch;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : watch
		pump_cmd_t got;
		pump_cmd_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {cmd_valid, duty_pct, run_ms};
				if (expected_cmds.size() == 0) begin
					report_mismatch("unexpected result", '0, got);
				end else begin
					want = expected_cmds.pop_front();
					if (got.ok !== want.ok || got.duty !== want.duty || got.dur !== want.dur)
						report_mismatch("result mismatch", want, got);
				end
			end
			if (cfg_wr_en)
				limit_ms = cfg_wr_data;
			if (in_valid && !in_stall)
				parse_request(op, rx_byte);
		end
	end

	task automatic push_byte(input logic is_err, input logic [7:0] c);
		rx_req_t req;
		req.op = is_err;
		req.ch = c;
		pending_reqs.push_back(req);
		items_sent++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(OP_BYTE, s[i]);
	endtask

	task automatic push_line(input string s);
		push_text(s);
		push_byte(OP_BYTE, CH_NL);
	endtask

	// A command whose run time is padded with leading zeros to the given stored length.
	task automatic push_padded(input int total);
		string s;
		s = "PUMP=1,TIME=";
		push_text(s);
		for (int i = s.len(); i < total - 1; i++)
			push_byte(OP_BYTE, CH_ZERO);
		push_byte(OP_BYTE, "7");
		push_byte(OP_BYTE, CH_NL);
	endtask

	// Pushes a command text, optionally replacing one character and slipping in a CR.
	task automatic push_cmd_text(input longint unsigned duty, input longint unsigned dur,
			input int mutate_at, input int cr_at);
		string s;
		s = {"PUMP=", $sformatf("%0d", duty), ",TIME=", $sformatf("%0d", dur)};
		for (int i = 0; i < s.len(); i++) begin
			if (i == cr_at)
				push_byte(OP_BYTE, CH_CR);
			if (i == mutate_at)
				push_byte(OP_BYTE, 8'($urandom_range(255)));
			else
				push_byte(OP_BYTE, s[i]);
		end
	endtask

	function automatic longint unsigned pick_duty();
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: return 64'($urandom_range(100));
			6: return 64'd0;
			7: return 64'd100;
			8: return 64'($urandom_range(999, 101));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic longint unsigned pick_time();
		longint unsigned lim;
		lim = {32'd0, limit_ms};
		case ($urandom_range(9))
			0, 1, 2: return 64'($urandom_range(999));
			3, 4: return {32'd0, $urandom} % (lim + 64'd1);
			5: return lim;
			6: return lim + 64'd1;
			7: return 64'd0;
			8: return {32'd0, $urandom};
			default: return 64'd4294967296 + 64'($urandom_range(99999));
		endcase
	endfunction

	task automatic gen_random_line();
		int r;
		int n;
		r = $urandom_range(99);
		if (r < 70) begin
			push_cmd_text(pick_duty(), pick_time(),
				($urandom_range(99) < 15) ? $urandom_range(25) : -1,
				($urandom_range(99) < 10) ? $urandom_range(20) : -1);
			if ($urandom_range(3) == 0)
				push_byte(OP_BYTE, CH_CR);
			push_byte(OP_BYTE, CH_NL);
		end else if (r < 78) begin
			// The zero byte ends the text; whatever follows is only counted.
			if ($urandom_range(1) == 0)
				push_text("PUMP=1");
			else
				push_cmd_text(pick_duty(), pick_time(), -1, -1);
			push_byte(OP_BYTE, 8'h00);
			n = $urandom_range(4);
			for (int i = 0; i < n; i++)
				push_byte(OP_BYTE, 8'($urandom_range(255)));
			push_byte(OP_BYTE, CH_NL);
		end else if (r < 86) begin
			n = $urandom_range(20, 1);
			for (int i = 0; i < n; i++)
				push_byte(OP_BYTE, 8'($urandom_range(255)));
			push_byte(OP_BYTE, CH_NL);
		end else if (r < 92) begin
			push_text("PUMP=");
			n = $urandom_range(3);
			for (int i = 0; i < n; i++)
				push_byte(OP_BYTE, 8'($urandom_range(255)));
			push_byte(OP_RX_ERR, 8'($urandom_range(255)));
			push_cmd_text(pick_duty(), pick_time(), -1, -1);
			push_byte(OP_BYTE, CH_NL);
		end else if (r < 96) begin
			if ($urandom_range(1) == 0)
				push_byte(OP_BYTE, CH_CR);
			push_byte(OP_BYTE, CH_NL);
		end else begin
			push_padded($urandom_range(LINE_LEN + 2, LINE_LEN - 2));
		end
	endtask

	task automatic write_limit(input logic [31:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Waits until every request is taken and every command has come out, then lets
	// the core settle.
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid || expected_cmds.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin : main_seq
		int goal;
		logic [31:0] lim;
		in_valid = 1'b0;
		op = OP_BYTE;
		rx_byte = '0;
		out_stall = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed lines against the limit left by reset.
		push_line("PUMP=50,TIME=1000");
		push_line("PUMP=0,TIME=0");
		push_line("PUMP=0,TIME=99999");
		push_text("PUMP=100,TIME=60000");
		push_byte(OP_BYTE, CH_CR);
		push_byte(OP_BYTE, CH_NL);
		push_line("PUMP=101,TIME=5");
		push_line("PUMP=7,TIME=0");
		push_line("PUMP=7,TIME=60001");
		push_line("pump=1,TIME=1");
		push_line("PUMP=1,TIME=5x");
		push_byte(OP_BYTE, CH_NL);
		push_byte(OP_BYTE, CH_CR);
		push_byte(OP_BYTE, CH_NL);
		push_text("PUMP=1,TIME=5");
		push_byte(OP_BYTE, 8'h00);
		push_line("zz");
		push_text("PUMP=1");
		push_byte(OP_BYTE, 8'h00);
		push_byte(OP_BYTE, CH_NL);
		push_text("PUMP=3,T");
		push_byte(OP_RX_ERR, 8'hff);
		push_line(",TIME=3");
		push_byte(OP_BYTE, 8'hff);
		push_byte(OP_BYTE, 8'h80);
		push_byte(OP_BYTE, CH_NL);
		push_padded(LINE_LEN - 1);
		push_padded(LINE_LEN);
		push_line("PUMP=2,TIME=2");
		wait_drained();

		write_limit(32'hffff_ffff);
		push_line("PUMP=100,TIME=4294967295");
		push_line("PUMP=1,TIME=4294967296");
		push_line("PUMP=4294967296,TIME=1");
		wait_drained();

		for (int phase_idx = 0; phase_idx < 4; phase_idx++) begin
			case (phase_idx)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
					lim = 32'd60000;
				end
				1: begin
					send_idle_pct = 88;
					stall_pct = 0;
					lim = 32'd0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 88;
					lim = 32'hffff_ffff;
				end
				default: begin
					send_idle_pct = 11;
					stall_pct = 11;
					lim = $urandom_range(200000);
				end
			endcase
			write_limit(lim);
			goal = items_sent + 75;
			while (items_sent < goal)
				gen_random_line();
			// The sender holds off here until the core has delivered everything.
			wait_drained();
			goal = items_sent + 75;
			while (items_sent < goal)
				gen_random_line();
			wait_drained();
		end

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/pclp_pkg.sv
rtl/core/pclp_front.sv
rtl/core/pclp_queue.sv
rtl/core/pclp_back.sv
rtl/core/pump_command_line_parser_core.sv
rtl/core/pclp_checker.sv
test/tb.sv
